### rtl/toe_pkg.sv
package toe_pkg;

    localparam int IDX_W = 12;
    localparam int CNT_W = 13;
    localparam int ACT_W = 2;
    localparam int OP_W  = 5;
    localparam int OPD_W = 5;
    localparam int OPD_NUM = 18;
    localparam int MAC_DIGIT_W = 16;
    localparam int SLOT_NUM = 6;
    localparam int SLOT_W = 3;

    // action codes
    localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OUTWARD = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MATCH   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE    = 2'd3;

    // register index
    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;

    // vertex read slots
    localparam logic [SLOT_W-1:0] SLOT_RA = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_RC = 3'd5;

    // operand select: base of each group plus axis
    localparam logic [OPD_W-1:0] OPD_E0 = 5'd0;
    localparam logic [OPD_W-1:0] OPD_E1 = 5'd3;
    localparam logic [OPD_W-1:0] OPD_E2 = 5'd6;
    localparam logic [OPD_W-1:0] OPD_E3 = 5'd9;
    localparam logic [OPD_W-1:0] OPD_NF = 5'd12;
    localparam logic [OPD_W-1:0] OPD_NR = 5'd15;
    localparam logic [OPD_W-1:0] AX_X = 5'd0;
    localparam logic [OPD_W-1:0] AX_Y = 5'd1;
    localparam logic [OPD_W-1:0] AX_Z = 5'd2;

    // multiply program
    localparam logic [OP_W-1:0] OP_REF_START  = 5'd6;
    localparam logic [OP_W-1:0] OP_DOT_OUT    = 5'd12;
    localparam logic [OP_W-1:0] OP_LAST_OUT   = 5'd14;
    localparam logic [OP_W-1:0] OP_DOT_MATCH  = 5'd15;
    localparam logic [OP_W-1:0] OP_LAST_MATCH = 5'd17;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DIFF,
        ST_ISSUE,
        ST_WAIT,
        ST_RESULT
    } toe_state_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_NF_X,
        DST_NF_Y,
        DST_NF_Z,
        DST_NR_X,
        DST_NR_Y,
        DST_NR_Z,
        DST_DOT
    } toe_dst_t;

    typedef struct packed {
        logic [OPD_W-1:0] a_sel;
        logic [OPD_W-1:0] b_sel;
        logic             sub;
        logic             clear;
        toe_dst_t         dst;
    } toe_op_t;

    typedef struct packed {
        logic start;
        logic sub;
        logic clear;
    } toe_mac_cmd_t;

    function automatic toe_op_t op_desc(input logic [OP_W-1:0] idx);
        toe_op_t          op;
        logic [OPD_W-1:0] p;
        logic [OPD_W-1:0] q;
        logic [OPD_W-1:0] n;
        logic [OP_W-1:0]  j;
        logic             is_ref;
        op = '0;
        is_ref = (idx >= OP_REF_START);
        p = is_ref ? OPD_E2 : OPD_E0;
        q = is_ref ? OPD_E3 : OPD_E1;
        j = is_ref ? OP_W'(idx - OP_REF_START) : idx;
        n = (idx >= OP_DOT_MATCH) ? OPD_NR : OPD_E2;
        if (idx < OP_DOT_OUT) begin
            case (j)
                5'd0: begin
                    op.a_sel = p + AX_Y; op.b_sel = q + AX_Z; op.clear = 1'b1;
                end
                5'd1: begin
                    op.a_sel = p + AX_Z; op.b_sel = q + AX_Y; op.sub = 1'b1;
                    op.dst = is_ref ? DST_NR_X : DST_NF_X;
                end
                5'd2: begin
                    op.a_sel = p + AX_Z; op.b_sel = q + AX_X; op.clear = 1'b1;
                end
                5'd3: begin
                    op.a_sel = p + AX_X; op.b_sel = q + AX_Z; op.sub = 1'b1;
                    op.dst = is_ref ? DST_NR_Y : DST_NF_Y;
                end
                5'd4: begin
                    op.a_sel = p + AX_X; op.b_sel = q + AX_Y; op.clear = 1'b1;
                end
                5'd5: begin
                    op.a_sel = p + AX_Y; op.b_sel = q + AX_X; op.sub = 1'b1;
                    op.dst = is_ref ? DST_NR_Z : DST_NF_Z;
                end
                default: op = '0;
            endcase
        end else begin
            j = (idx >= OP_DOT_MATCH) ? OP_W'(idx - OP_DOT_MATCH) : OP_W'(idx - OP_DOT_OUT);
            op.a_sel = OPD_NF + OPD_W'(j);
            op.b_sel = n + OPD_W'(j);
            op.clear = (j == 5'd0);
            op.dst   = (j == 5'd2) ? DST_DOT : DST_NONE;
        end
        return op;
    endfunction

endpackage

### rtl/toe_mac.sv
module toe_mac #(
    parameter int PW = 51,
    parameter int DW = 104
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  toe_pkg::toe_mac_cmd_t      cmd,
    input  logic signed [PW-1:0]       op_a,
    input  logic signed [PW-1:0]       op_b,
    output logic                       done,
    output logic signed [DW-1:0]       acc
);

    localparam int DG  = toe_pkg::MAC_DIGIT_W;
    localparam int ND  = (PW + DG - 1) / DG;
    localparam int BW  = ND * DG;
    localparam int PRW = 2 * PW;
    localparam int CW  = (ND > 1) ? $clog2(ND) : 1;

    logic [PW-1:0]         mag_a_reg;
    logic [BW-1:0]         mag_b_reg;
    logic [PRW-1:0]        prod_reg;
    logic                  neg_reg;
    logic                  clr_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  accum_reg;
    logic                  done_reg;
    logic signed [DW-1:0]  acc_reg;

    logic [PW-1:0]         mag_a_in;
    logic [PW-1:0]         mag_b_in;
    logic [PW+DG-1:0]      pp;
    logic signed [DW-1:0]  base;
    logic signed [DW-1:0]  prod_ext;

    assign mag_a_in = op_a[PW-1] ? PW'(-op_a) : op_a;
    assign mag_b_in = op_b[PW-1] ? PW'(-op_b) : op_b;
    assign pp       = mag_a_reg * mag_b_reg[BW-1 -: DG];
    assign base     = clr_reg ? '0 : acc_reg;
    assign prod_ext = $signed(DW'(prod_reg));

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            accum_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= accum_reg;
            accum_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ND - 1)) begin
                    busy_reg  <= 1'b0;
                    accum_reg <= 1'b1;
                end
            end
        end
    end

    // one 16-bit digit of the multiplier per step, msb first
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            mag_a_reg <= mag_a_in;
            mag_b_reg <= BW'(mag_b_in);
            neg_reg   <= op_a[PW-1] ^ op_b[PW-1] ^ cmd.sub;
            clr_reg   <= cmd.clear;
            prod_reg  <= '0;
        end else if (busy_reg) begin
            mag_b_reg <= mag_b_reg << DG;
            prod_reg  <= (prod_reg << DG) + PRW'(pp);
        end
        if (accum_reg) begin
            acc_reg <= neg_reg ? base - prod_ext : base + prod_ext;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(busy_reg && accum_reg))
        else $error("mac busy and accumulate at once");

    a_accum_done: assert property (@(posedge aclk) disable iff (!aresetn)
        accum_reg |=> done_reg)
        else $error("accumulate not followed by done");

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (!busy_reg && !accum_reg))
        else $error("mac started while working");

endmodule

### rtl/triangle_orientation_engine_core.sv
// channel   | ports                                   | dir | handshake
// ----------+-----------------------------------------+-----+-------------------------
// request   | s_action s_face_* s_ref_* s_coord_*     | in  | s_valid / s_ready
// result    | m_out_a m_out_b m_out_c m_flipped m_status | out | m_valid / m_ready
// config    | psel penable pwrite paddr pwdata prdata | in  | apb, pready tied high
//
// one request at a time; s_ready is high only while the engine is idle
// write, error and unused requests go straight from idle to the result state
// queries: 4 (outward) or 6 (match) store reads, a drain and an edge-difference setup
//   state, then 9 or 15 multiplies on one shared multiply unit
// the result waits in the output register; the next request is taken meanwhile
// synchronous active-low reset clears control only; store contents undefined until written
module triangle_orientation_engine_core #(
    parameter int MAX_VERTICES = 4096,
    parameter int COORD_BITS   = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [toe_pkg::ACT_W-1:0]     s_action,
    input  logic [toe_pkg::IDX_W-1:0]     s_face_a,
    input  logic [toe_pkg::IDX_W-1:0]     s_face_b,
    input  logic [toe_pkg::IDX_W-1:0]     s_face_c,
    input  logic [toe_pkg::IDX_W-1:0]     s_ref_a,
    input  logic [toe_pkg::IDX_W-1:0]     s_ref_b,
    input  logic [toe_pkg::IDX_W-1:0]     s_ref_c,
    input  logic signed [COORD_BITS-1:0]  s_coord_x,
    input  logic signed [COORD_BITS-1:0]  s_coord_y,
    input  logic signed [COORD_BITS-1:0]  s_coord_z,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [toe_pkg::IDX_W-1:0]     m_out_a,
    output logic [toe_pkg::IDX_W-1:0]     m_out_b,
    output logic [toe_pkg::IDX_W-1:0]     m_out_c,
    output logic                          m_flipped,
    output logic                          m_status,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [1:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CW    = COORD_BITS;
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CMP_W = (toe_pkg::CNT_W > AW + 1) ? toe_pkg::CNT_W : AW + 1;
    localparam int PW    = 2 * CW + 3;     // difference and normal operands
    localparam int DW    = 2 * PW + 2;     // exact dot product
    localparam int IW    = toe_pkg::IDX_W;

    toe_pkg::toe_state_t state_reg, state_next;

    logic [toe_pkg::CNT_W-1:0] vertex_count_reg;

    // latched request
    logic [toe_pkg::ACT_W-1:0] act_reg;
    logic [IW-1:0]             idx_reg [toe_pkg::SLOT_NUM];

    // pending result
    logic [IW-1:0] res_a_reg, res_b_reg, res_c_reg;
    logic          res_flip_reg, res_status_reg;

    // output register
    logic          m_valid_reg;
    logic [IW-1:0] m_a_reg, m_b_reg, m_c_reg;
    logic          m_flip_reg, m_status_reg;

    // vertex store and read path
    logic [3*CW-1:0]               mem [MAX_VERTICES];
    logic [3*CW-1:0]               rd_data_reg;
    logic [toe_pkg::SLOT_W-1:0]    rd_idx_reg;
    logic                          cap_valid_reg;
    logic [toe_pkg::SLOT_W-1:0]    cap_slot_reg;
    logic [3*CW-1:0]               vtx_reg [toe_pkg::SLOT_NUM];

    // edge vectors and normals
    logic signed [CW:0]   e_reg  [4][3];
    logic signed [PW-1:0] nf_reg [3];
    logic signed [PW-1:0] nr_reg [3];

    logic [toe_pkg::OP_W-1:0] op_idx_reg;
    toe_pkg::toe_op_t         op;

    logic signed [PW-1:0] opnd [toe_pkg::OPD_NUM];
    toe_pkg::toe_mac_cmd_t mac_cmd;
    logic                  mac_done;
    logic signed [DW-1:0]  mac_acc;

    logic                  accept;
    logic [CMP_W-1:0]      limit;
    logic                  face_err, ref_err, query_err, wr_err;
    logic                  mem_we;
    logic                  rd_en;
    logic                  out_load;
    logic                  is_out;
    logic                  last_op;
    logic                  flip;
    logic [toe_pkg::SLOT_W-1:0] last_slot;

    function automatic logic signed [CW:0] dif(input logic [CW-1:0] a, input logic [CW-1:0] b);
        dif = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    endfunction

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr == toe_pkg::REG_VERTEX_COUNT) ? 32'(vertex_count_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr == toe_pkg::REG_VERTEX_COUNT) begin
            vertex_count_reg <= pwdata[toe_pkg::CNT_W-1:0];
        end
    end

    // range check against min(vertex_count, store depth)
    assign limit = (CMP_W'(vertex_count_reg) < CMP_W'(MAX_VERTICES))
                 ? CMP_W'(vertex_count_reg) : CMP_W'(MAX_VERTICES);
    assign face_err = (CMP_W'(s_face_a) >= limit) || (CMP_W'(s_face_b) >= limit)
                   || (CMP_W'(s_face_c) >= limit) || (CMP_W'(s_ref_a) >= limit);
    assign ref_err  = (CMP_W'(s_ref_b) >= limit) || (CMP_W'(s_ref_c) >= limit);
    assign query_err = face_err || (s_action == toe_pkg::ACT_MATCH && ref_err);
    assign wr_err    = CMP_W'(s_face_a) >= CMP_W'(MAX_VERTICES);

    assign accept = s_valid && s_ready;
    assign mem_we = accept && s_action == toe_pkg::ACT_WRITE && !wr_err;
    assign is_out = act_reg == toe_pkg::ACT_OUTWARD;
    assign last_slot = is_out ? toe_pkg::SLOT_RA : toe_pkg::SLOT_RC;
    assign op = toe_pkg::op_desc(op_idx_reg);
    assign last_op = is_out ? (op_idx_reg == toe_pkg::OP_LAST_OUT)
                            : (op_idx_reg == toe_pkg::OP_LAST_MATCH);
    assign flip = is_out ? (!mac_acc[DW-1] && (mac_acc != '0)) : mac_acc[DW-1];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            toe_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if ((s_action == toe_pkg::ACT_OUTWARD || s_action == toe_pkg::ACT_MATCH)
                        && !query_err) begin
                        state_next = toe_pkg::ST_READ;
                    end else begin
                        state_next = toe_pkg::ST_RESULT;
                    end
                end
            end
            toe_pkg::ST_READ: begin
                if (rd_idx_reg == last_slot) begin
                    state_next = toe_pkg::ST_DRAIN;
                end
            end
            toe_pkg::ST_DRAIN:  state_next = toe_pkg::ST_DIFF;
            toe_pkg::ST_DIFF:   state_next = toe_pkg::ST_ISSUE;
            toe_pkg::ST_ISSUE:  state_next = toe_pkg::ST_WAIT;
            toe_pkg::ST_WAIT: begin
                if (mac_done) begin
                    state_next = last_op ? toe_pkg::ST_RESULT : toe_pkg::ST_ISSUE;
                end
            end
            toe_pkg::ST_RESULT: begin
                if (out_load) begin
                    state_next = toe_pkg::ST_IDLE;
                end
            end
            default: state_next = toe_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready       = 1'b0;
        rd_en         = 1'b0;
        out_load      = 1'b0;
        mac_cmd       = '0;
        case (state_reg)
            toe_pkg::ST_IDLE:   s_ready = 1'b1;
            toe_pkg::ST_READ:   rd_en = 1'b1;
            toe_pkg::ST_ISSUE: begin
                mac_cmd.start = 1'b1;
                mac_cmd.sub   = op.sub;
                mac_cmd.clear = op.clear;
            end
            toe_pkg::ST_RESULT: out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= toe_pkg::ST_IDLE;
            cap_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cap_valid_reg <= rd_en;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // vertex store: one write port at request time, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[AW'(s_face_a)] <= {s_coord_x, s_coord_y, s_coord_z};
        end
        if (rd_en) begin
            rd_data_reg <= mem[AW'(idx_reg[rd_idx_reg])];
        end
    end

    // request latch and result setup
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg    <= s_action;
            idx_reg[0] <= s_face_a;
            idx_reg[1] <= s_face_b;
            idx_reg[2] <= s_face_c;
            idx_reg[3] <= s_ref_a;
            idx_reg[4] <= s_ref_b;
            idx_reg[5] <= s_ref_c;
            rd_idx_reg <= '0;
            op_idx_reg <= '0;
            res_flip_reg <= 1'b0;
            case (s_action)
                toe_pkg::ACT_OUTWARD, toe_pkg::ACT_MATCH: begin
                    res_a_reg      <= s_face_a;
                    res_b_reg      <= s_face_b;
                    res_c_reg      <= s_face_c;
                    res_status_reg <= query_err;
                end
                toe_pkg::ACT_WRITE: begin
                    res_a_reg      <= '0;
                    res_b_reg      <= '0;
                    res_c_reg      <= '0;
                    res_status_reg <= wr_err;
                end
                default: begin
                    res_a_reg      <= '0;
                    res_b_reg      <= '0;
                    res_c_reg      <= '0;
                    res_status_reg <= 1'b0;
                end
            endcase
        end
        if (rd_en) begin
            rd_idx_reg <= rd_idx_reg + 1'b1;
        end
        cap_slot_reg <= rd_idx_reg;
        if (cap_valid_reg) begin
            vtx_reg[cap_slot_reg] <= rd_data_reg;
        end

        // edge vectors; for match the third and fourth run along the reference triangle
        if (state_reg == toe_pkg::ST_DIFF) begin
            for (int k = 0; k < 3; k++) begin
                e_reg[0][k] <= dif(vtx_reg[1][(3-k)*CW-1 -: CW], vtx_reg[0][(3-k)*CW-1 -: CW]);
                e_reg[1][k] <= dif(vtx_reg[2][(3-k)*CW-1 -: CW], vtx_reg[0][(3-k)*CW-1 -: CW]);
                if (is_out) begin
                    e_reg[2][k] <= dif(vtx_reg[3][(3-k)*CW-1 -: CW],
                                       vtx_reg[0][(3-k)*CW-1 -: CW]);
                end else begin
                    e_reg[2][k] <= dif(vtx_reg[4][(3-k)*CW-1 -: CW],
                                       vtx_reg[3][(3-k)*CW-1 -: CW]);
                end
                e_reg[3][k] <= dif(vtx_reg[5][(3-k)*CW-1 -: CW], vtx_reg[3][(3-k)*CW-1 -: CW]);
            end
        end

        // write back finished sums
        if (state_reg == toe_pkg::ST_WAIT && mac_done) begin
            if (is_out && op_idx_reg == toe_pkg::OP_REF_START - 1'b1) begin
                op_idx_reg <= toe_pkg::OP_DOT_OUT;
            end else if (!is_out && op_idx_reg == toe_pkg::OP_DOT_OUT - 1'b1) begin
                op_idx_reg <= toe_pkg::OP_DOT_MATCH;
            end else begin
                op_idx_reg <= op_idx_reg + 1'b1;
            end
            case (op.dst)
                toe_pkg::DST_NF_X: nf_reg[0] <= mac_acc[PW-1:0];
                toe_pkg::DST_NF_Y: nf_reg[1] <= mac_acc[PW-1:0];
                toe_pkg::DST_NF_Z: nf_reg[2] <= mac_acc[PW-1:0];
                toe_pkg::DST_NR_X: nr_reg[0] <= mac_acc[PW-1:0];
                toe_pkg::DST_NR_Y: nr_reg[1] <= mac_acc[PW-1:0];
                toe_pkg::DST_NR_Z: nr_reg[2] <= mac_acc[PW-1:0];
                toe_pkg::DST_DOT: begin
                    // zero dot product never flips
                    if (flip) begin
                        res_b_reg    <= res_c_reg;
                        res_c_reg    <= res_b_reg;
                        res_flip_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (out_load) begin
            m_a_reg      <= res_a_reg;
            m_b_reg      <= res_b_reg;
            m_c_reg      <= res_c_reg;
            m_flip_reg   <= res_flip_reg;
            m_status_reg <= res_status_reg;
        end
    end

    // operand file for the multiply unit
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            opnd[toe_pkg::OPD_E0 + k] = PW'(e_reg[0][k]);
            opnd[toe_pkg::OPD_E1 + k] = PW'(e_reg[1][k]);
            opnd[toe_pkg::OPD_E2 + k] = PW'(e_reg[2][k]);
            opnd[toe_pkg::OPD_E3 + k] = PW'(e_reg[3][k]);
            opnd[toe_pkg::OPD_NF + k] = nf_reg[k];
            opnd[toe_pkg::OPD_NR + k] = nr_reg[k];
        end
    end

    toe_mac #(
        .PW (PW),
        .DW (DW)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .op_a    (opnd[op.a_sel]),
        .op_b    (opnd[op.b_sel]),
        .done    (mac_done),
        .acc     (mac_acc)
    );

    assign m_valid   = m_valid_reg;
    assign m_out_a   = m_a_reg;
    assign m_out_b   = m_b_reg;
    assign m_out_c   = m_c_reg;
    assign m_flipped = m_flip_reg;
    assign m_status  = m_status_reg;

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> state_reg == toe_pkg::ST_WAIT)
        else $error("multiply finished outside wait state");

    a_capture_in_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_valid_reg |-> (state_reg == toe_pkg::ST_READ || state_reg == toe_pkg::ST_DRAIN))
        else $error("store data captured outside read phase");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == toe_pkg::ST_RESULT && m_valid_reg && !m_ready)
        |=> state_reg == toe_pkg::ST_RESULT)
        else $error("result dropped while output stalled");

endmodule

### sim/tb_triangle_orientation_engine_core.sv
`timescale 1ns / 1ps

module tb_triangle_orientation_engine_core;

    localparam int NVERT  = 4096;
    localparam int CW     = 24;
    localparam int CLK_NS = 10;

    typedef logic signed [127:0] wide_t;

    // one request as seen on the input channel
    typedef struct {
        logic [toe_pkg::ACT_W-1:0] action;
        logic [toe_pkg::IDX_W-1:0] fa, fb, fc, ra, rb, rc;
        logic signed [CW-1:0]      x, y, z;
    } tri_req_t;

    // one result as seen on the output channel
    typedef struct {
        logic [toe_pkg::IDX_W-1:0] a, b, c;
        logic                      flipped;
        logic                      status;
    } tri_res_t;

    // directed row: optional register write before, optional typed result
    typedef struct {
        logic                      cfg_on;
        logic [toe_pkg::CNT_W-1:0] cfg_val;
        tri_req_t                  req;
        logic                      typed;
        tri_res_t                  res;
    } dir_row_t;

    logic aclk;
    logic aresetn;

    logic                      s_valid;
    logic                      s_ready;
    logic [toe_pkg::ACT_W-1:0] s_action;
    logic [toe_pkg::IDX_W-1:0] s_face_a, s_face_b, s_face_c;
    logic [toe_pkg::IDX_W-1:0] s_ref_a, s_ref_b, s_ref_c;
    logic signed [CW-1:0]      s_coord_x, s_coord_y, s_coord_z;

    logic                      m_valid;
    logic                      m_ready;
    logic [toe_pkg::IDX_W-1:0] m_out_a, m_out_b, m_out_c;
    logic                      m_flipped;
    logic                      m_status;

    logic                 psel, penable, pwrite;
    logic [1:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    triangle_orientation_engine_core #(
        .MAX_VERTICES (NVERT),
        .COORD_BITS   (CW)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_face_a  (s_face_a),
        .s_face_b  (s_face_b),
        .s_face_c  (s_face_c),
        .s_ref_a   (s_ref_a),
        .s_ref_b   (s_ref_b),
        .s_ref_c   (s_ref_c),
        .s_coord_x (s_coord_x),
        .s_coord_y (s_coord_y),
        .s_coord_z (s_coord_z),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_a   (m_out_a),
        .m_out_b   (m_out_b),
        .m_out_c   (m_out_c),
        .m_flipped (m_flipped),
        .m_status  (m_status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // shadow of the vertex store and the count register
    logic signed [CW-1:0]      pos_x [NVERT];
    logic signed [CW-1:0]      pos_y [NVERT];
    logic signed [CW-1:0]      pos_z [NVERT];
    bit                        pos_written [NVERT];
    int                        written_list [$];
    logic [toe_pkg::CNT_W-1:0] vertex_limit_reg;

    tri_res_t orient_q [$];
    int       mismatches;
    bit       hold_off_req;
    bit       no_idle;

    // clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_NS / 2) aclk = ~aclk;
    end

    // watchdog
    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor: exact wide arithmetic, sign tests on the full product
    // ------------------------------------------------------------------
    function automatic void tri_normal(input int i0, input int i1, input int i2,
                                       output wide_t nx, output wide_t ny,
                                       output wide_t nz);
        wide_t ux, uy, uz, vx, vy, vz;
        ux = wide_t'(pos_x[i1]) - wide_t'(pos_x[i0]);
        uy = wide_t'(pos_y[i1]) - wide_t'(pos_y[i0]);
        uz = wide_t'(pos_z[i1]) - wide_t'(pos_z[i0]);
        vx = wide_t'(pos_x[i2]) - wide_t'(pos_x[i0]);
        vy = wide_t'(pos_y[i2]) - wide_t'(pos_y[i0]);
        vz = wide_t'(pos_z[i2]) - wide_t'(pos_z[i0]);
        nx = uy * vz - uz * vy;
        ny = uz * vx - ux * vz;
        nz = ux * vy - uy * vx;
    endfunction

    function automatic tri_res_t orient_predict(input tri_req_t r);
        tri_res_t res;
        int       lim;
        wide_t    nx, ny, nz, mx, my, mz, dot;
        logic     bad;
        res = '{default: '0};
        lim = (vertex_limit_reg < NVERT) ? int'(vertex_limit_reg) : NVERT;
        if (r.action == toe_pkg::ACT_WRITE) begin
            pos_x[r.fa] = r.x;
            pos_y[r.fa] = r.y;
            pos_z[r.fa] = r.z;
            if (!pos_written[r.fa]) written_list.insert(written_list.size(), int'(r.fa));
            pos_written[r.fa] = 1'b1;
            return res;
        end
        if (r.action == toe_pkg::ACT_NONE) return res;
        res.a = r.fa;
        res.b = r.fb;
        res.c = r.fc;
        bad = (r.fa >= lim) || (r.fb >= lim) || (r.fc >= lim) || (r.ra >= lim) ||
              (r.action == toe_pkg::ACT_MATCH && ((r.rb >= lim) || (r.rc >= lim)));
        if (bad) begin
            res.status = 1'b1;
            return res;
        end
        tri_normal(r.fa, r.fb, r.fc, nx, ny, nz);
        if (r.action == toe_pkg::ACT_OUTWARD) begin
            dot = nx * (wide_t'(pos_x[r.ra]) - wide_t'(pos_x[r.fa]))
                + ny * (wide_t'(pos_y[r.ra]) - wide_t'(pos_y[r.fa]))
                + nz * (wide_t'(pos_z[r.ra]) - wide_t'(pos_z[r.fa]));
            res.flipped = (dot > 0);
        end else begin
            tri_normal(r.ra, r.rb, r.rc, mx, my, mz);
            dot = nx * mx + ny * my + nz * mz;
            res.flipped = (dot < 0);
        end
        if (res.flipped) begin
            res.b = r.fc;
            res.c = r.fb;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // checking of accepted results
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %0d got %0d at %0t", what, exp_v, got_v, $time);
    endtask

    always @(posedge aclk) begin
        tri_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (orient_q.size() == 0) begin
                report_mismatch("unexpected result, out_a", -1, m_out_a);
            end else begin
                want = orient_q.pop_front();
                if (m_out_a !== want.a) report_mismatch("out_a", want.a, m_out_a);
                if (m_out_b !== want.b) report_mismatch("out_b", want.b, m_out_b);
                if (m_out_c !== want.c) report_mismatch("out_c", want.c, m_out_c);
                if (m_flipped !== want.flipped)
                    report_mismatch("flipped", want.flipped, m_flipped);
                if (m_status !== want.status)
                    report_mismatch("status", want.status, m_status);
            end
        end
    end

    // ------------------------------------------------------------------
    // result side back-pressure, with one long hold-off on request
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready = 1'b0;
                repeat (400) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            stall = no_idle ? 0 : pick_gap();
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic send_request(input tri_req_t r, input logic typed, input tri_res_t typed_res);
        tri_res_t pred;
        int       gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_action  = r.action;
        s_face_a  = r.fa;
        s_face_b  = r.fb;
        s_face_c  = r.fc;
        s_ref_a   = r.ra;
        s_ref_b   = r.rb;
        s_ref_c   = r.rc;
        s_coord_x = r.x;
        s_coord_y = r.y;
        s_coord_z = r.z;
        s_valid   = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = orient_predict(r);
        orient_q.insert(orient_q.size(), typed ? typed_res : pred);
        @(negedge aclk);
    endtask

    // wait for every outstanding result, then let the engine settle
    task automatic drain_results();
        s_valid = 1'b0;
        while (orient_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_vertex_count(input logic [toe_pkg::CNT_W-1:0] val);
        drain_results();
        paddr   = 2'(toe_pkg::REG_VERTEX_COUNT * 4);
        pwdata  = 32'(val);
        pwrite  = 1'b1;
        psel    = 1'b1;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        vertex_limit_reg = val;
        // read back
        pwrite  = 1'b0;
        psel    = 1'b1;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (prdata[toe_pkg::CNT_W-1:0] !== val)
            report_mismatch("vertex_count readback", val, prdata);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic tri_req_t mk(input logic [toe_pkg::ACT_W-1:0] act,
                                    input int fa, input int fb, input int fc,
                                    input int ra, input int rb, input int rc,
                                    input int x, input int y, input int z);
        tri_req_t r;
        r.action = act;
        r.fa = toe_pkg::IDX_W'(fa); r.fb = toe_pkg::IDX_W'(fb); r.fc = toe_pkg::IDX_W'(fc);
        r.ra = toe_pkg::IDX_W'(ra); r.rb = toe_pkg::IDX_W'(rb); r.rc = toe_pkg::IDX_W'(rc);
        r.x = CW'(x); r.y = CW'(y); r.z = CW'(z);
        return r;
    endfunction

    function automatic tri_res_t mk_res(input int a, input int b, input int c,
                                        input logic fl, input logic st);
        tri_res_t r;
        r.a = toe_pkg::IDX_W'(a); r.b = toe_pkg::IDX_W'(b); r.c = toe_pkg::IDX_W'(c);
        r.flipped = fl;
        r.status = st;
        return r;
    endfunction

    // random index: mostly a written vertex, sometimes one at or beyond the end of the valid range
    function automatic int pick_index();
        int lim;
        lim = (vertex_limit_reg < NVERT) ? int'(vertex_limit_reg) : NVERT;
        if (lim < NVERT && $urandom_range(0, 19) == 0) return $urandom_range(lim, NVERT - 1);
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 6) - 3;                // tiny, many zero dots
            1: return $urandom_range(0, 2047) - 1024;
            default: return int'($signed(CW'($urandom())));  // full range
        endcase
    endfunction

    function automatic tri_req_t random_request();
        tri_req_t r;
        int       k, src;
        k = $urandom_range(0, 99);
        r = mk(toe_pkg::ACT_WRITE, pick_index(), pick_index(), pick_index(),
               pick_index(), pick_index(), pick_index(), 0, 0, 0);
        if (k < 35) begin
            r.action = toe_pkg::ACT_WRITE;
            r.fa = ($urandom_range(0, 3) == 0) ? toe_pkg::IDX_W'($urandom())
                                               : toe_pkg::IDX_W'($urandom_range(0, 31));
            if ($urandom_range(0, 9) == 0 && written_list.size() > 0) begin
                // duplicate a vertex to build degenerate triangles
                src = written_list[$urandom_range(0, written_list.size() - 1)];
                r.x = pos_x[src]; r.y = pos_y[src]; r.z = pos_z[src];
            end else begin
                r.x = CW'(pick_coord()); r.y = CW'(pick_coord()); r.z = CW'(pick_coord());
            end
            r.fb = toe_pkg::IDX_W'($urandom()); r.fc = toe_pkg::IDX_W'($urandom());
            r.ra = toe_pkg::IDX_W'($urandom()); r.rb = toe_pkg::IDX_W'($urandom());
            r.rc = toe_pkg::IDX_W'($urandom());
        end else begin
            if (k < 65)      r.action = toe_pkg::ACT_OUTWARD;
            else if (k < 95) r.action = toe_pkg::ACT_MATCH;
            else             r.action = toe_pkg::ACT_NONE;
            r.x = CW'($urandom()); r.y = CW'($urandom()); r.z = CW'($urandom());
            if (r.action == toe_pkg::ACT_OUTWARD) begin
                r.rb = toe_pkg::IDX_W'($urandom()); r.rc = toe_pkg::IDX_W'($urandom());
            end
            if (r.action == toe_pkg::ACT_NONE) begin
                r.fa = toe_pkg::IDX_W'($urandom()); r.fb = toe_pkg::IDX_W'($urandom());
                r.fc = toe_pkg::IDX_W'($urandom()); r.ra = toe_pkg::IDX_W'($urandom());
            end
        end
        return r;
    endfunction

    // directed table
    dir_row_t dir_rows [$];
    tri_res_t none_res;

    task automatic add_row(input logic cfg_on, input int cfg_val, input tri_req_t r,
                           input logic typed, input tri_res_t res);
        dir_row_t row;
        row.cfg_on = cfg_on;
        row.cfg_val = toe_pkg::CNT_W'(cfg_val);
        row.req = r;
        row.typed = typed;
        row.res = res;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    initial begin
        tri_res_t zr;
        int       counts [4];
        zr = mk_res(0, 0, 0, 1'b0, 1'b0);
        none_res = zr;
        mismatches = 0;
        hold_off_req = 1'b0;
        no_idle = 1'b0;
        vertex_limit_reg = '0;
        s_valid = 1'b0;
        s_action = toe_pkg::ACT_WRITE;
        {s_face_a, s_face_b, s_face_c, s_ref_a, s_ref_b, s_ref_c} = '0;
        {s_coord_x, s_coord_y, s_coord_z} = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        aresetn = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // unit tetrahedron plus a collinear point and the coordinate extremes
        add_row(0, 0, mk(toe_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zr);
        add_row(0, 0, mk(toe_pkg::ACT_WRITE, 1, 0, 0, 0, 0, 0, 256, 0, 0), 1, zr);
        add_row(0, 0, mk(toe_pkg::ACT_WRITE, 2, 0, 0, 0, 0, 0, 0, 256, 0), 1, zr);
        add_row(0, 0, mk(toe_pkg::ACT_WRITE, 3, 0, 0, 0, 0, 0, 0, 0, 256), 1, zr);
        add_row(0, 0, mk(toe_pkg::ACT_WRITE, 4, 0, 0, 0, 0, 0, 0, 0, -256), 1, zr);
        add_row(0, 0, mk(toe_pkg::ACT_WRITE, 5, 0, 0, 0, 0, 0, 512, 0, 0), 1, zr);
        add_row(0, 0, mk(toe_pkg::ACT_WRITE, 4095, 4095, 4095, 4095, 4095, 4095,
                         8388607, 8388607, 8388607), 1, zr);
        add_row(0, 0, mk(toe_pkg::ACT_WRITE, 7, 0, 0, 0, 0, 0,
                         -8388608, -8388608, -8388608), 1, zr);
        add_row(0, 0, mk(toe_pkg::ACT_WRITE, 6, 0, 0, 0, 0, 0, -8388608, 8388607, 0), 1, zr);
        // count still zero after reset: every query is out of range
        add_row(0, 0, mk(toe_pkg::ACT_OUTWARD, 0, 1, 2, 3, 0, 0, 0, 0, 0), 1,
                mk_res(0, 1, 2, 0, 1));
        // unused action code answers all zero
        add_row(0, 0, mk(toe_pkg::ACT_NONE, 4095, 4095, 4095, 4095, 4095, 4095, -1, -1, -1),
                1, zr);
        // small valid range
        add_row(1, 8, mk(toe_pkg::ACT_OUTWARD, 0, 1, 2, 3, 0, 0, 0, 0, 0), 0, zr);
        add_row(0, 0, mk(toe_pkg::ACT_OUTWARD, 0, 1, 2, 4, 0, 0, 0, 0, 0), 0, zr);
        add_row(0, 0, mk(toe_pkg::ACT_OUTWARD, 0, 1, 5, 3, 0, 0, 0, 0, 0), 0, zr);  // degenerate
        add_row(0, 0, mk(toe_pkg::ACT_OUTWARD, 0, 1, 2, 5, 0, 0, 0, 0, 0), 0, zr);  // coplanar
        add_row(0, 0, mk(toe_pkg::ACT_MATCH, 0, 1, 2, 0, 2, 1, 0, 0, 0), 0, zr);    // opposing
        add_row(0, 0, mk(toe_pkg::ACT_MATCH, 0, 1, 2, 0, 1, 2, 0, 0, 0), 0, zr);
        add_row(0, 0, mk(toe_pkg::ACT_MATCH, 0, 1, 5, 0, 1, 2, 0, 0, 0), 0, zr);
        add_row(0, 0, mk(toe_pkg::ACT_OUTWARD, 0, 1, 8, 3, 0, 0, 0, 0, 0), 1,
                mk_res(0, 1, 8, 0, 1));
        add_row(0, 0, mk(toe_pkg::ACT_OUTWARD, 0, 1, 2, 9, 0, 0, 0, 0, 0), 1,
                mk_res(0, 1, 2, 0, 1));
        add_row(0, 0, mk(toe_pkg::ACT_MATCH, 0, 1, 2, 0, 1, 4095, 0, 0, 0), 1,
                mk_res(0, 1, 2, 0, 1));
        add_row(0, 0, mk(toe_pkg::ACT_OUTWARD, 7, 6, 1, 2, 0, 0, 0, 0, 0), 0, zr);
        // full range, extreme coordinates
        add_row(1, 4096, mk(toe_pkg::ACT_OUTWARD, 4095, 7, 6, 0, 0, 0, 0, 0, 0), 0, zr);
        add_row(0, 0, mk(toe_pkg::ACT_MATCH, 4095, 7, 0, 7, 4095, 6, 0, 0, 0), 0, zr);
        add_row(1, 8191, mk(toe_pkg::ACT_MATCH, 6, 7, 4095, 3, 2, 1, 0, 0, 0), 0, zr);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_on) write_vertex_count(dir_rows[i].cfg_val);
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        end

        // random phases at several range settings
        counts[0] = 4096;
        counts[1] = 16;
        counts[2] = $urandom_range(1, 4096);
        counts[3] = 8191;
        foreach (counts[p]) begin
            write_vertex_count(toe_pkg::CNT_W'(counts[p]));
            for (int n = 0; n < 170; n++) begin
                no_idle = (n >= 60 && n < 90);
                if (p == 0 && n == 100) hold_off_req = 1'b1;   // result side stops for a while
                if (n == 130) drain_results();                 // sender waits for all results
                send_request(random_request(), 1'b0, none_res);
            end
            no_idle = 1'b0;
        end
        write_vertex_count('0);
        send_request(mk(toe_pkg::ACT_MATCH, 0, 1, 2, 0, 1, 2, 0, 0, 0), 1,
                     mk_res(0, 1, 2, 0, 1));

        s_valid = 1'b0;
        while (orient_q.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (mismatches == 0 && orient_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
rtl/toe_pkg.sv
rtl/toe_mac.sv
rtl/triangle_orientation_engine_core.sv
sim/tb_triangle_orientation_engine_core.sv
